@@ src/lga_pkg.sv @@
package lga_pkg;

  localparam int DATA_W    = 16;
  localparam int LANES     = 6;
  localparam int LANE_W    = 3;
  localparam int ERR_W     = 36;
  localparam int PROD_W    = ERR_W + DATA_W;
  localparam int SUM_W     = 64;
  localparam int CNT_W     = 9;
  localparam int CNT_MAX   = 511;
  localparam int CFG_IDX_W = 3;

  // register map of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BIAS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_W0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_W5   = 3'd6;

  localparam logic [DATA_W-1:0] BIAS_RESET = 16'd256;
  localparam logic [DATA_W-1:0] W0_RESET   = 16'd128;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DOT,
    S_DOT_END,
    S_GRAD,
    S_GRAD_END,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic              load;
    logic              mul_en;
    logic              mul_grad;
    logic [LANE_W-1:0] lane;
    logic              dot_acc;
    logic              grad_acc;
    logic [LANE_W-1:0] acc_lane;
    logic              bias_acc;
    logic              emit;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic last;
    logic out_free;
  } status_t;

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

endpackage

@@ src/lga_ctrl.sv @@
module lga_ctrl import lga_pkg::*; #(
  parameter int FEATURE_COUNT = 6
) (
  input  logic    clk,
  input  logic    rst_n,
  input  status_t status,
  output cmd_t    cmd,
  output logic    in_ready
);

  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(FEATURE_COUNT - 1);

  state_t            state_r, state_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lane_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lane_nxt  = lane_r;
    case (state_r)
      S_IDLE: begin
        lane_nxt = '0;
        if (status.in_valid) state_nxt = S_DOT;
      end
      S_DOT: begin
        if (lane_r == LAST_LANE) begin
          state_nxt = S_DOT_END;
          lane_nxt  = '0;
        end else begin
          lane_nxt = lane_r + 1'b1;
        end
      end
      S_DOT_END: state_nxt = S_GRAD;
      S_GRAD: begin
        if (lane_r == LAST_LANE) begin
          state_nxt = S_GRAD_END;
          lane_nxt  = '0;
        end else begin
          lane_nxt = lane_r + 1'b1;
        end
      end
      S_GRAD_END: state_nxt = status.last ? S_EMIT : S_IDLE;
      S_EMIT: begin
        if (status.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.lane = lane_r;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = status.in_valid;
      end
      S_DOT: begin
        cmd.mul_en  = 1'b1;
        cmd.dot_acc = 1'b1;
      end
      S_DOT_END: cmd.dot_acc = 1'b1;
      S_GRAD: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_grad = 1'b1;
        cmd.grad_acc = (lane_r != '0);
        cmd.acc_lane = lane_r - 1'b1;
      end
      S_GRAD_END: begin
        cmd.grad_acc = 1'b1;
        cmd.acc_lane = LAST_LANE;
        cmd.bias_acc = 1'b1;
      end
      S_EMIT: cmd.emit = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ src/lga_datapath.sv @@
module lga_datapath import lga_pkg::*; #(
  parameter int MAX_EXAMPLES = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic signed [DATA_W-1:0] in_feature [LANES],
  input  logic signed [DATA_W-1:0] in_target,
  input  logic                     in_last,
  input  logic                     in_valid,
  input  logic                     out_ready,
  input  cmd_t                     cmd,
  output status_t                  status,
  output logic                     out_valid,
  output logic signed [SUM_W-1:0]  out_grad [LANES],
  output logic signed [SUM_W-1:0]  out_bias,
  output logic [CNT_W-1:0]         out_count
);

  localparam int COUNT_CAP = (MAX_EXAMPLES < CNT_MAX) ? MAX_EXAMPLES : CNT_MAX;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(COUNT_CAP);

  logic signed [DATA_W-1:0] bias_r;
  logic signed [DATA_W-1:0] w_r [LANES];
  logic signed [DATA_W-1:0] f_r [LANES];
  logic                     last_r;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  sum_r [LANES];
  logic signed [SUM_W-1:0]  bias_sum_r;
  logic [CNT_W-1:0]         count_r;
  logic signed [SUM_W-1:0]  grad_r [LANES];
  logic signed [SUM_W-1:0]  out_bias_r;
  logic [CNT_W-1:0]         out_count_r;
  logic                     out_valid_r;

  logic signed [ERR_W-1:0]  a_op;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ERR_W-1:0]  err_init;
  logic signed [SUM_W-1:0]  lane_sum_nxt;
  logic signed [SUM_W-1:0]  bias_sum_nxt;
  logic [CFG_IDX_W-1:0]     w_idx;

  // shared multiplier: weight times feature, then error times feature
  always_comb begin
    a_op = cmd.mul_grad ? err_r : {{(ERR_W-DATA_W){w_r[cmd.lane][DATA_W-1]}}, w_r[cmd.lane]};
    prod_nxt = a_op * f_r[cmd.lane];
  end

  assign err_init = ({{(ERR_W-DATA_W){bias_r[DATA_W-1]}}, bias_r}
                   - {{(ERR_W-DATA_W){in_target[DATA_W-1]}}, in_target}) <<< 8;

  assign lane_sum_nxt = sat_add(sum_r[cmd.acc_lane],
                                {{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});
  assign bias_sum_nxt = sat_add(bias_sum_r, {{(SUM_W-ERR_W){err_r[ERR_W-1]}}, err_r});
  assign w_idx        = cfg_index - REG_W0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= BIAS_RESET;
      for (int i = 0; i < LANES; i++) w_r[i] <= (i == 0) ? W0_RESET : '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_BIAS) begin
        bias_r <= cfg_data;
      end else if (cfg_index >= REG_W0 && cfg_index <= REG_W5) begin
        w_r[w_idx] <= cfg_data;
      end
    end
  end

  // example registers and multiplier pipeline
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < LANES; i++) f_r[i] <= in_feature[i];
      last_r <= in_last;
      err_r  <= err_init;
      prod_r <= '0;
    end else begin
      if (cmd.dot_acc) err_r <= err_r + $signed(prod_r[ERR_W-1:0]);
      if (cmd.mul_en) prod_r <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) sum_r[i] <= '0;
      bias_sum_r <= '0;
      count_r    <= '0;
    end else if (cmd.emit) begin
      for (int i = 0; i < LANES; i++) sum_r[i] <= '0;
      bias_sum_r <= '0;
      count_r    <= '0;
    end else begin
      if (cmd.grad_acc) sum_r[cmd.acc_lane] <= lane_sum_nxt;
      if (cmd.bias_acc) begin
        bias_sum_r <= bias_sum_nxt;
        if (count_r < CAP) count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      for (int i = 0; i < LANES; i++) grad_r[i] <= sum_r[i];
      out_bias_r  <= bias_sum_r;
      out_count_r <= count_r;
    end
  end

  assign status.in_valid = in_valid;
  assign status.last     = last_r;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_grad  = grad_r;
  assign out_bias  = out_bias_r;
  assign out_count = out_count_r;

endmodule

@@ src/linreg_gradient_accumulator_unit.sv @@
// batch gradient accumulator for a six-feature linear model. each example word carries
// six signed q8.8 features, a q8.8 target and a last flag; the unit forms the error
// (bias + sum of weight * feature - target, q20.16) and adds error * feature (q28.24)
// to one 64-bit sum per feature and the error to a bias sum, all saturating. a word
// flagged last is accumulated, then the sums and the example count go out as one result
// word and the sums clear. one shared multiplier walks the features twice, and a new
// word is taken only once the previous one is through both passes; a last word also
// waits in an emit state while the previous result is still in the output register.
// weights and bias are written through the cfg port; the user must write them only
// while idle, as the block itself does not enforce it
module linreg_gradient_accumulator_unit import lga_pkg::*; #(
  parameter int FEATURE_COUNT = 6,
  parameter int MAX_EXAMPLES  = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration writes
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  // example words
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_feature_0,
  input  logic signed [DATA_W-1:0] in_feature_1,
  input  logic signed [DATA_W-1:0] in_feature_2,
  input  logic signed [DATA_W-1:0] in_feature_3,
  input  logic signed [DATA_W-1:0] in_feature_4,
  input  logic signed [DATA_W-1:0] in_feature_5,
  input  logic signed [DATA_W-1:0] in_target_value,
  input  logic                     in_last_example,
  // result words
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SUM_W-1:0]  out_grad_w0,
  output logic signed [SUM_W-1:0]  out_grad_w1,
  output logic signed [SUM_W-1:0]  out_grad_w2,
  output logic signed [SUM_W-1:0]  out_grad_w3,
  output logic signed [SUM_W-1:0]  out_grad_w4,
  output logic signed [SUM_W-1:0]  out_grad_w5,
  output logic signed [SUM_W-1:0]  out_grad_bias,
  output logic [CNT_W-1:0]         out_example_count
);

  cmd_t                     cmd;
  status_t                  status;
  logic signed [DATA_W-1:0] feature [LANES];
  logic signed [SUM_W-1:0]  grad [LANES];

  // gather the feature ports into lanes
  assign feature[0] = in_feature_0;
  assign feature[1] = in_feature_1;
  assign feature[2] = in_feature_2;
  assign feature[3] = in_feature_3;
  assign feature[4] = in_feature_4;
  assign feature[5] = in_feature_5;

  // sequencer: accept, dot product pass, gradient pass, emit
  lga_ctrl #(
    .FEATURE_COUNT(FEATURE_COUNT)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .status  (status),
    .cmd     (cmd),
    .in_ready(in_ready)
  );

  // weights, shared multiplier, saturating sums and output register
  lga_datapath #(
    .MAX_EXAMPLES(MAX_EXAMPLES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_feature(feature),
    .in_target (in_target_value),
    .in_last   (in_last_example),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_grad  (grad),
    .out_bias  (out_grad_bias),
    .out_count (out_example_count)
  );

  // unused lanes never accumulate, so their sums read as zero
  assign out_grad_w0 = grad[0];
  assign out_grad_w1 = grad[1];
  assign out_grad_w2 = grad[2];
  assign out_grad_w3 = grad[3];
  assign out_grad_w4 = grad[4];
  assign out_grad_w5 = grad[5];

endmodule

@@ verif/tb_linreg_gradient_accumulator_unit.sv @@
module tb_linreg_gradient_accumulator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lga_pkg::*;

  // block build under test and the limits that follow from it
  localparam int FEATURES    = 6;
  localparam int MAX_EX      = 256;
  localparam int COUNT_CAP   = (MAX_EX < CNT_MAX) ? MAX_EX : CNT_MAX;

  // register index the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  // q8.8 extremes
  localparam logic signed [DATA_W-1:0] Q_MIN = 16'sh8000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 16'sh7fff;

  // cycles the block may still be busy on a word once nothing is expected
  // (the dot product and gradient passes and the emit state, with margin)
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 6;
  // short run of extreme words with the largest error
  localparam int SOAK_WORDS    = 32;

  typedef logic signed [DATA_W-1:0] q88_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct {
    q88_t feat [LANES];
    q88_t target;
    logic last;
  } example_t;

  typedef struct {
    sum_t             grad [LANES];
    sum_t             bias;
    logic [CNT_W-1:0] count;
  } grad_word_t;

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    q88_t                 data;
  } reg_write_t;

  typedef enum {ROW_EXAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    example_t             ex;
    bit                   typed;
    grad_word_t           want;
    logic [CFG_IDX_W-1:0] idx;
    q88_t                 data;
  } stim_row_t;

  // ports, all known from time zero
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  q88_t                 in_feature_0    = '0;
  q88_t                 in_feature_1    = '0;
  q88_t                 in_feature_2    = '0;
  q88_t                 in_feature_3    = '0;
  q88_t                 in_feature_4    = '0;
  q88_t                 in_feature_5    = '0;
  q88_t                 in_target_value = '0;
  logic                 in_last_example = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  sum_t                 out_grad_w0;
  sum_t                 out_grad_w1;
  sum_t                 out_grad_w2;
  sum_t                 out_grad_w3;
  sum_t                 out_grad_w4;
  sum_t                 out_grad_w5;
  sum_t                 out_grad_bias;
  logic [CNT_W-1:0]     out_example_count;

  linreg_gradient_accumulator_unit #(
    .FEATURE_COUNT(FEATURES),
    .MAX_EXAMPLES (MAX_EX)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_feature_0     (in_feature_0),
    .in_feature_1     (in_feature_1),
    .in_feature_2     (in_feature_2),
    .in_feature_3     (in_feature_3),
    .in_feature_4     (in_feature_4),
    .in_feature_5     (in_feature_5),
    .in_target_value  (in_target_value),
    .in_last_example  (in_last_example),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_grad_w0      (out_grad_w0),
    .out_grad_w1      (out_grad_w1),
    .out_grad_w2      (out_grad_w2),
    .out_grad_w3      (out_grad_w3),
    .out_grad_w4      (out_grad_w4),
    .out_grad_w5      (out_grad_w5),
    .out_grad_bias    (out_grad_bias),
    .out_example_count(out_example_count)
  );

  // shadow of the weight and bias registers
  q88_t bias_shadow;
  q88_t weight_shadow [LANES];

  // shadow of the accumulators
  sum_t lane_sums [LANES];
  sum_t bias_sum;
  int   batch_count;

  grad_word_t pending_gradients [$];
  reg_write_t write_queue [$];
  stim_row_t  directed_rows [$];

  int fault_count  = 0;
  bit no_idle      = 1'b0;
  bit hold_off_req = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  // generous ceiling on the whole run
  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // two's complement add that clamps at the 64-bit limits
  function automatic sum_t clamp_add(input sum_t a, input sum_t b);
    sum_t s;
    s = a + b;
    if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1])
      s = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    return s;
  endfunction

  // folds one example into the shadow sums; returns 1 with the gradient word
  // when the example closes the batch
  function automatic bit accumulate_example(input example_t ex, output grad_word_t word);
    longint pred;
    longint err;
    pred = longint'(bias_shadow) * 256;
    for (int j = 0; j < FEATURES; j++)
      pred += longint'(weight_shadow[j]) * longint'(ex.feat[j]);
    err = pred - longint'(ex.target) * 256;
    for (int j = 0; j < FEATURES; j++)
      lane_sums[j] = clamp_add(lane_sums[j], err * longint'(ex.feat[j]));
    bias_sum = clamp_add(bias_sum, err);
    if (batch_count < COUNT_CAP) batch_count++;
    if (!ex.last) return 1'b0;
    for (int j = 0; j < LANES; j++) word.grad[j] = (j < FEATURES) ? lane_sums[j] : '0;
    word.bias  = bias_sum;
    word.count = batch_count[CNT_W-1:0];
    for (int j = 0; j < LANES; j++) lane_sums[j] = '0;
    bias_sum    = '0;
    batch_count = 0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic example_t mk_ex(input q88_t f0, input q88_t f1, input q88_t f2,
                                     input q88_t f3, input q88_t f4, input q88_t f5,
                                     input q88_t t, input logic last);
    example_t ex;
    ex.feat[0] = f0;
    ex.feat[1] = f1;
    ex.feat[2] = f2;
    ex.feat[3] = f3;
    ex.feat[4] = f4;
    ex.feat[5] = f5;
    ex.target  = t;
    ex.last    = last;
    return ex;
  endfunction

  // hand-worked word: lane 0, the other lanes, bias sum and count
  function automatic grad_word_t expected_word(input sum_t g0, input sum_t g_rest,
                                               input sum_t b, input int cnt);
    grad_word_t w;
    w.grad[0] = g0;
    for (int j = 1; j < LANES; j++) w.grad[j] = g_rest;
    w.bias  = b;
    w.count = cnt[CNT_W-1:0];
    return w;
  endfunction

  function automatic void add_example(input example_t ex);
    stim_row_t r;
    r.kind  = ROW_EXAMPLE;
    r.ex    = ex;
    r.typed = 1'b0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_checked(input example_t ex, input grad_word_t want);
    stim_row_t r;
    r.kind  = ROW_EXAMPLE;
    r.ex    = ex;
    r.typed = 1'b1;
    r.want  = want;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input q88_t data);
    stim_row_t r;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.data  = data;
    r.typed = 1'b0;
    directed_rows.push_back(r);
  endfunction

  function automatic void queue_write(input logic [CFG_IDX_W-1:0] idx, input q88_t data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    write_queue.push_back(w);
  endfunction

  // full-range values and small magnitudes in equal share, with extremes mixed in
  function automatic q88_t random_q88();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return q88_t'($urandom);
    if (r < 6) begin
      case ($urandom_range(0, 3))
        0: return Q_MIN;
        1: return Q_MAX;
        2: return q88_t'(0);
        default: return q88_t'(-1);
      endcase
    end
    return q88_t'(int'($urandom_range(0, 4095)) - 2048);
  endfunction

  function automatic example_t random_example(input logic last);
    example_t ex;
    for (int j = 0; j < LANES; j++) ex.feat[j] = random_q88();
    ex.target = random_q88();
    ex.last   = last;
    return ex;
  endfunction

  // idle stretch: mostly none or short, now and then long
  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic int batch_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 4);
    if (r < 93) return $urandom_range(5, 16);
    return $urandom_range(17, 64);
  endfunction

  function automatic void note_fault(input string msg);
    if (fault_count < 10) $display("mismatch: %s", msg);
    fault_count++;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offers one example word and holds it until the block takes it; a typed
  // expectation, where given, stands in for the predicted one
  task automatic offer_example(input example_t ex, input bit typed, input grad_word_t want);
    grad_word_t predicted;
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_feature_0    <= ex.feat[0];
    in_feature_1    <= ex.feat[1];
    in_feature_2    <= ex.feat[2];
    in_feature_3    <= ex.feat[3];
    in_feature_4    <= ex.feat[4];
    in_feature_5    <= ex.feat[5];
    in_target_value <= ex.target;
    in_last_example <= ex.last;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    // taken at this edge
    if (accumulate_example(ex, predicted)) begin
      if (typed) pending_gradients.push_back(want);
      else pending_gradients.push_back(predicted);
    end
  endtask

  // stop offering, let every gradient word out and the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_gradients.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // back-to-back register writes, one per edge
  task automatic flush_writes();
    reg_write_t w;
    while (write_queue.size() > 0) begin
      w = write_queue.pop_front();
      cfg_we    <= 1'b1;
      cfg_index <= w.idx;
      cfg_data  <= w.data;
      @(posedge clk);
      if (w.idx == REG_BIAS) bias_shadow = w.data;
      else if (w.idx >= REG_W0 && w.idx <= REG_W5) weight_shadow[w.idx - REG_W0] = w.data;
    end
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver side
  // ---------------------------------------------------------------------------

  task automatic check_word();
    grad_word_t want;
    sum_t       got [LANES];
    got[0] = out_grad_w0;
    got[1] = out_grad_w1;
    got[2] = out_grad_w2;
    got[3] = out_grad_w3;
    got[4] = out_grad_w4;
    got[5] = out_grad_w5;
    if (pending_gradients.size() == 0) begin
      note_fault("gradient word with nothing expected");
    end else begin
      want = pending_gradients.pop_front();
      for (int j = 0; j < LANES; j++)
        if (got[j] !== want.grad[j])
          note_fault($sformatf("grad_w%0d expected %0d got %0d", j, want.grad[j], got[j]));
      if (out_grad_bias !== want.bias)
        note_fault($sformatf("grad_bias expected %0d got %0d", want.bias, out_grad_bias));
      if (out_example_count !== want.count)
        note_fault($sformatf("example_count expected %0d got %0d",
                             want.count, out_example_count));
    end
  endtask

  // takes result words with random back-pressure; a hold-off request from the
  // sender side blocks the output for a long counted stretch
  initial begin : result_sink
    int gap_left;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_ready) check_word();
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        gap_left = 0;
      end
      if (gap_left > 0) begin
        out_ready <= 1'b0;
        gap_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) gap_left = idle_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    grad_word_t none;
    example_t   soak_ex;
    int         left;
    int         len;
    bit         long_done;

    // shadows start at the register and sum reset values
    bias_shadow = BIAS_RESET;
    for (int j = 0; j < LANES; j++) begin
      weight_shadow[j] = '0;
      lane_sums[j]     = '0;
    end
    weight_shadow[0] = W0_RESET;
    bias_sum    = '0;
    batch_count = 0;

    // directed table
    // reset weights: bias 1.0, weight 0 = 0.5, everything else zero
    add_checked(mk_ex(0, 0, 0, 0, 0, 0, 0, 1'b1), expected_word(0, 0, 65536, 1));
    add_checked(mk_ex(256, 0, 0, 0, 0, 0, 0, 1'b1), expected_word(25165824, 0, 98304, 1));
    // target equal to the bias gives zero error
    add_checked(mk_ex(0, 0, 0, 0, 0, 0, 256, 1'b1), expected_word(0, 0, 0, 1));
    add_example(mk_ex(Q_MAX, -1, 300, -300, Q_MIN, 1, 100, 1'b0));
    add_example(mk_ex(-5, 16'sh5555, 16'sh2aaa, -16'sh2aab, 77, -77, -256, 1'b0));
    add_example(mk_ex(1, 2, 3, 4, 5, 6, Q_MAX, 1'b1));
    // all registers at the top of their range
    add_write(REG_BIAS, Q_MAX);
    for (int j = 0; j < LANES; j++) add_write(CFG_IDX_W'(REG_W0 + j), Q_MAX);
    add_example(mk_ex(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, 1'b0));
    add_example(mk_ex(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, 1'b0));
    add_example(mk_ex(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0, 1'b1));
    // zero model, and a write to the unused index that must change nothing
    add_write(REG_BIAS, 0);
    for (int j = 0; j < LANES; j++) add_write(CFG_IDX_W'(REG_W0 + j), 0);
    add_write(REG_NONE, 16'sh5a5a);
    add_checked(mk_ex(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1),
                expected_word(-64'sd274877906944, -64'sd274877906944, 8388608, 1));
    // all registers at the bottom of their range
    add_write(REG_BIAS, Q_MIN);
    for (int j = 0; j < LANES; j++) add_write(CFG_IDX_W'(REG_W0 + j), Q_MIN);
    add_example(mk_ex(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, 1'b0));
    add_example(mk_ex(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, 1'b1));
    // alternating weights, then a batch left open across the next phase
    add_write(REG_BIAS, 1);
    for (int j = 0; j < LANES; j++)
      add_write(CFG_IDX_W'(REG_W0 + j), (j % 2) ? Q_MIN : Q_MAX);
    add_example(mk_ex(Q_MAX, Q_MAX, 0, 0, -1, -1, 0, 1'b0));
    add_example(mk_ex(-1, 1, -1, 1, -1, 1, -1, 1'b0));
    add_example(mk_ex(16'sh0100, 16'sh0080, 16'sh0040, 16'sh0020, 16'sh0010, 16'sh0008,
                      16'sh0001, 1'b1));
    add_example(mk_ex(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, 1'b0));

    // synchronous reset, held from time zero and then released
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        settle();
        queue_write(directed_rows[i].idx, directed_rows[i].data);
        flush_writes();
      end else begin
        offer_example(directed_rows[i].ex, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          queue_write(REG_BIAS, Q_MAX);
          for (int j = 0; j < LANES; j++) queue_write(CFG_IDX_W'(REG_W0 + j), Q_MAX);
        end
        1: begin
          queue_write(REG_BIAS, Q_MIN);
          for (int j = 0; j < LANES; j++) queue_write(CFG_IDX_W'(REG_W0 + j), Q_MIN);
        end
        2: begin
          // weights off: error is bias minus target alone
          queue_write(REG_BIAS, random_q88());
          for (int j = 0; j < LANES; j++) queue_write(CFG_IDX_W'(REG_W0 + j), 0);
        end
        default: begin
          if ($urandom_range(0, 1)) queue_write(REG_BIAS, random_q88());
          for (int j = 0; j < LANES; j++)
            if ($urandom_range(0, 1)) queue_write(CFG_IDX_W'(REG_W0 + j), random_q88());
          queue_write(REG_NONE, random_q88());
        end
      endcase
      flush_writes();
      // one phase runs flat out on both sides
      no_idle = (phase == 4);

      if (phase == 2) begin
        // output blocked while single-word batches keep coming: the result
        // register fills and the input has to stall
        hold_off_req = 1'b1;
        repeat (40) offer_example(random_example(1'b1), 1'b0, none);
        // then wait for the backlog to drain before going on
        settle();
      end

      left      = (phase == 3) ? 360 : 200;
      long_done = 1'b0;
      while (left > 0) begin
        len = batch_length();
        if (phase == 3 && !long_done) begin
          // batch longer than the count limit
          len       = 300;
          long_done = 1'b1;
        end
        // the final batch of a phase may stay open into the next one
        for (int k = 0; k < len && left > 0; k++) begin
          offer_example(random_example(k == len - 1), 1'b0, none);
          left--;
        end
      end
    end

    // extreme words with a large positive error pull lanes 0-2 negative and
    // lanes 3-5 positive, then random words follow on the same sums
    settle();
    queue_write(REG_BIAS, Q_MAX);
    for (int j = 0; j < LANES; j++)
      queue_write(CFG_IDX_W'(REG_W0 + j), (j < 3) ? Q_MIN : Q_MAX);
    flush_writes();
    no_idle = 1'b1;
    soak_ex = mk_ex(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, 1'b0);
    repeat (SOAK_WORDS) offer_example(soak_ex, 1'b0, none);
    no_idle = 1'b0;
    for (int k = 0; k < 24; k++) offer_example(random_example(k == 23), 1'b0, none);

    // drain and give the block time to show anything stray
    in_valid <= 1'b0;
    while (pending_gradients.size() > 0) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    if (fault_count == 0 && pending_gradients.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/lga_pkg.sv
src/lga_ctrl.sv
src/lga_datapath.sv
src/linreg_gradient_accumulator_unit.sv
verif/tb_linreg_gradient_accumulator_unit.sv
